@@ rtl/assert_macros.svh @@
// Assertion macros shared by the sonar plotter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SSP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ssp_pkg.sv @@
// Shared types, constants and the sine table of the sonar sweep plotter.
package ssp_pkg;

  localparam int SWEEP_STEPS_DEF = 400;
  localparam int ROW_BYTES_DEF   = 20;
  localparam int QUEUE_DEPTH     = 2;

  localparam int TICKS_W   = 24;
  localparam int SCAN_W    = 4;
  localparam int STEP_W    = 9;
  localparam int ADDR_W    = 12;
  localparam int MASK_W    = 8;
  localparam int SCAN_LIMIT_RST = 2;

  localparam int CIRCLE_STEPS  = 400;
  localparam int QUARTER_STEPS = 100;
  localparam int PHASE_W       = 9;
  localparam int QIDX_W        = $clog2(QUARTER_STEPS + 1);
  localparam int SIN_STEP_Q30  = 16865604;
  localparam int COS_STEP_Q30  = 1073609359;

  // range = ticks*69632/11875 through a rounded-up reciprocal; anything at or above 2^22
  // ticks, or any range that does not fit in 24 bits, saturates to all ones
  localparam longint unsigned RANGE_NUMER   = 64'd69632;
  localparam longint unsigned RANGE_DIVISOR = 64'd11875;
  localparam int              RANGE_SHIFT   = 36;
  localparam longint unsigned RANGE_RECIP   =
    ((RANGE_NUMER << RANGE_SHIFT) + RANGE_DIVISOR - 64'd1) / RANGE_DIVISOR;
  localparam int NEAR_W     = 22;
  localparam int RECIP_LO_W = 20;
  localparam int RECIP_HI_W = 19;
  localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_LO_W'(RANGE_RECIP);
  localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_HI_W'(RANGE_RECIP >> RECIP_LO_W);
  localparam int PROD_LO_W  = NEAR_W + RECIP_LO_W;
  localparam int PROD_HI_W  = NEAR_W + RECIP_HI_W;
  localparam int SCALE_W    = PROD_HI_W + RECIP_LO_W;
  localparam int RANGE_W    = 24;
  localparam int PROD_W     = 41;

  typedef logic [QUARTER_STEPS:0][14:0] qsin_t;

  typedef struct packed {
    logic [TICKS_W-1:0] echo_ticks;
    logic [STEP_W-1:0]  step_index;
    logic [PHASE_W-1:0] sin_idx;
    logic [PHASE_W-1:0] cos_idx;
    logic               sweep_done;
  } ssp_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCALE,
    BK_RANGE,
    BK_MUL,
    BK_PLOT,
    BK_OUT
  } bk_state_t;

  // Quarter-wave Q1.15 sine from a Q30 recurrence.
  function automatic qsin_t build_qsin();
    logic [63:0] s [0:QUARTER_STEPS];
    logic [63:0] t;
    logic [63:0] r;
    qsin_t       q;
    s[0] = 64'd0;
    s[1] = 64'(SIN_STEP_Q30);
    for (int k = 1; k < QUARTER_STEPS; k++) begin
      t = (64'd2 * 64'(COS_STEP_Q30) * s[k] + (64'd1 << 29)) >> 30;
      s[k+1] = (t < s[k-1]) ? 64'd0 : t - s[k-1];
    end
    for (int k = 0; k <= QUARTER_STEPS; k++) begin
      r = (s[k] * 64'd32767 + (64'd1 << 29)) >> 30;
      q[k] = (r > 64'd32767) ? 15'd32767 : r[14:0];
    end
    return q;
  endfunction

  localparam qsin_t QSIN = build_qsin();

  function automatic logic signed [15:0] sin_lookup(input logic [PHASE_W-1:0] idx);
    logic [PHASE_W-1:0] k;
    logic               neg;
    logic [14:0]        mag;
    if (idx <= PHASE_W'(QUARTER_STEPS)) begin
      k   = idx;
      neg = 1'b0;
    end else if (idx <= PHASE_W'(2 * QUARTER_STEPS)) begin
      k   = PHASE_W'(2 * QUARTER_STEPS) - idx;
      neg = 1'b0;
    end else if (idx <= PHASE_W'(3 * QUARTER_STEPS)) begin
      k   = idx - PHASE_W'(2 * QUARTER_STEPS);
      neg = 1'b1;
    end else begin
      k   = PHASE_W'(CIRCLE_STEPS) - idx;
      neg = 1'b1;
    end
    mag = QSIN[k[QIDX_W-1:0]];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

@@ rtl/ssp_intf.sv @@
// Channel interfaces: echo input, plot result and scan limit write.
interface ssp_echo_if;
  logic        valid;
  logic        ready;
  logic [23:0] echo_ticks;
  modport source (output valid, output echo_ticks, input ready);
  modport sink (input valid, input echo_ticks, output ready);
endinterface

interface ssp_result_if;
  logic        valid;
  logic        ready;
  logic        plot_valid;
  logic [11:0] pixel_address;
  logic [7:0]  pixel_mask;
  logic [8:0]  step_index;
  logic        sweep_done;
  modport source (output valid, output plot_valid, output pixel_address,
                  output pixel_mask, output step_index, output sweep_done,
                  input ready);
  modport sink (input valid, input plot_valid, input pixel_address,
                input pixel_mask, input step_index, input sweep_done,
                output ready);
endinterface

interface ssp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] scan_limit;
  modport source (output valid, output scan_limit, input ready);
  modport sink (input valid, input scan_limit, output ready);
endinterface

@@ rtl/ssp_fifo.sv @@
// Short item queue between the sweep front end and the plot back end.
module ssp_fifo
  import ssp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ssp_job_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ssp_job_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssp_job_t         mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ssp_front.sv @@
// Front end: accepts echoes, tracks sweep angle and scan count, queues jobs.
module ssp_front
  import ssp_pkg::*;
#(
  parameter int SWEEP_STEPS = SWEEP_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  ssp_echo_if.sink echo,
  ssp_cfg_if.sink  cfg,
  output logic     push_valid,
  input  logic     push_ready,
  output ssp_job_t push_data
);

  localparam int ANGLE_W = $clog2(SWEEP_STEPS + 1);

  logic [ANGLE_W-1:0] angle;
  logic [ANGLE_W-1:0] angle_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic               reverse;
  logic               reverse_next;
  logic [SCAN_W-1:0]  scans;
  logic [SCAN_W-1:0]  scans_next;
  logic [SCAN_W-1:0]  scans_inc;
  logic [SCAN_W-1:0]  scan_limit;
  logic               done;
  logic [PHASE_W:0]   cos_sum;
  logic [PHASE_W-1:0] cos_idx;
  logic               accept;

  assign echo.ready = push_ready;
  assign cfg.ready  = 1'b1;
  assign accept     = echo.valid && push_ready;
  assign push_valid = echo.valid;

  always_comb begin
    done      = (scans >= scan_limit);
    scans_inc = (scans == '1) ? scans : scans + 1'b1;
    cos_sum   = (PHASE_W + 1)'(phase) + (PHASE_W + 1)'(QUARTER_STEPS);
    cos_idx   = (cos_sum >= (PHASE_W + 1)'(CIRCLE_STEPS))
              ? PHASE_W'(cos_sum - (PHASE_W + 1)'(CIRCLE_STEPS))
              : PHASE_W'(cos_sum);

    angle_next   = angle;
    phase_next   = phase;
    reverse_next = reverse;
    scans_next   = scans;
    if (!done) begin
      if (!reverse) begin
        angle_next = angle + 1'b1;
        phase_next = (phase == PHASE_W'(CIRCLE_STEPS - 1)) ? '0 : phase + 1'b1;
        if (angle_next >= ANGLE_W'(SWEEP_STEPS)) begin
          reverse_next = 1'b1;
          scans_next   = scans_inc;
        end
      end else begin
        if (angle != '0) begin
          angle_next = angle - 1'b1;
          phase_next = (phase == '0) ? PHASE_W'(CIRCLE_STEPS - 1) : phase - 1'b1;
        end
        if (angle_next == '0) begin
          reverse_next = 1'b0;
          scans_next   = scans_inc;
        end
      end
    end

    push_data.echo_ticks = echo.echo_ticks;
    push_data.step_index = STEP_W'(angle);
    push_data.sin_idx    = phase;
    push_data.cos_idx    = cos_idx;
    push_data.sweep_done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle      <= '0;
      phase      <= '0;
      reverse    <= 1'b0;
      scans      <= '0;
      scan_limit <= SCAN_W'(SCAN_LIMIT_RST);
    end else begin
      if (accept) begin
        angle   <= angle_next;
        phase   <= phase_next;
        reverse <= reverse_next;
        scans   <= scans_next;
      end
      if (cfg.valid) begin
        scan_limit <= cfg.scan_limit;
      end
    end
  end

endmodule

@@ rtl/ssp_back.sv @@
// Back end: range scaling, polar to cartesian products, window test and pixel address.
module ssp_back
  import ssp_pkg::*;
#(
  parameter int ROW_BYTES = ROW_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  ssp_job_t     pop_data,
  ssp_result_if.source result
);

  localparam logic signed [PROD_W-1:0] X_HI  = PROD_W'(80) <<< 31;
  localparam logic signed [PROD_W-1:0] X_OFF = PROD_W'(79) <<< 31;
  localparam logic signed [PROD_W-1:0] Y_HI  = PROD_W'(63) <<< 31;
  localparam logic signed [PROD_W-1:0] Y_LO  = -(PROD_W'(64) <<< 31);

  bk_state_t state;
  bk_state_t state_next;

  ssp_job_t                   job;
  logic [NEAR_W-1:0]          near_ticks;
  logic                       far;
  logic [PROD_HI_W-1:0]       prod_hi;
  logic [PROD_LO_W-1:0]       prod_lo;
  logic [RANGE_W-1:0]         range_val;
  logic signed [15:0]         sin_val;
  logic signed [15:0]         cos_val;
  logic signed [PROD_W-1:0]   px;
  logic signed [PROD_W-1:0]   py;
  logic                       inwin;
  logic [7:0]                 tx;
  logic [6:0]                 ty;

  logic [SCALE_W-1:0]         scale_sum;
  logic [RANGE_W:0]           range_q;
  logic [RANGE_W-1:0]         range_sat;
  logic signed [PROD_W-1:0]   tx_sum;
  logic signed [PROD_W-1:0]   ty_sum;
  logic [15:0]                addr_full;
  logic                       load_out;

  logic                       out_valid;
  logic                       out_plot;
  logic [ADDR_W-1:0]          out_addr;
  logic [MASK_W-1:0]          out_mask;
  logic [STEP_W-1:0]          out_step;
  logic                       out_done;

  assign result.valid         = out_valid;
  assign result.plot_valid    = out_plot;
  assign result.pixel_address = out_addr;
  assign result.pixel_mask    = out_mask;
  assign result.step_index    = out_step;
  assign result.sweep_done    = out_done;

  always_comb begin
    scale_sum = {prod_hi, {RECIP_LO_W{1'b0}}} + SCALE_W'(prod_lo);
    range_q   = scale_sum[SCALE_W-1:RANGE_SHIFT];
    range_sat = (far || range_q[RANGE_W]) ? '1 : range_q[RANGE_W-1:0];
    tx_sum    = px + X_OFF;
    ty_sum    = Y_HI - py;
    addr_full = 16'(tx[7:3]) + 16'(ty) * 16'(ROW_BYTES);
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = pop_data.sweep_done ? BK_OUT : BK_SCALE;
        end
      end
      BK_SCALE: begin
        state_next = BK_RANGE;
      end
      BK_RANGE: begin
        state_next = BK_MUL;
      end
      BK_MUL: begin
        state_next = BK_PLOT;
      end
      BK_PLOT: begin
        state_next = BK_OUT;
      end
      BK_OUT: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          job        <= pop_data;
          near_ticks <= pop_data.echo_ticks[NEAR_W-1:0];
          far        <= (pop_data.echo_ticks[TICKS_W-1:NEAR_W] != '0);
          sin_val    <= sin_lookup(pop_data.sin_idx);
          cos_val    <= sin_lookup(pop_data.cos_idx);
          inwin      <= 1'b0;
        end
      end
      BK_SCALE: begin
        prod_hi <= near_ticks * RECIP_HI;
        prod_lo <= near_ticks * RECIP_LO;
      end
      BK_RANGE: begin
        range_val <= range_sat;
      end
      BK_MUL: begin
        px <= $signed({1'b0, range_val}) * cos_val;
        py <= $signed({1'b0, range_val}) * sin_val;
      end
      BK_PLOT: begin
        inwin <= (px >= 0) && (px <= X_HI) && (py >= Y_LO) && (py <= Y_HI);
        tx    <= tx_sum[38:31];
        ty    <= ty_sum[37:31];
      end
      BK_OUT: begin
      end
    endcase
    if (load_out) begin
      out_plot <= inwin && !job.sweep_done;
      out_addr <= (inwin && !job.sweep_done) ? addr_full[ADDR_W-1:0] : '0;
      out_mask <= (inwin && !job.sweep_done) ? (8'h80 >> tx[2:0]) : '0;
      out_step <= job.step_index;
      out_done <= job.sweep_done;
    end
  end

endmodule

@@ rtl/sonar_sweep_polar_plotter_unit.sv @@
// Top level of the sonar sweep polar plotter.
// Flow: an echo passes the queue, then the back end's scale, range, multiply, window and
//   output steps; an echo taken after the sweep is done goes straight to the output step,
//   and the result then waits for ready. The back end takes a new echo only after the
//   last one has left its output step; the queue decouples the front end.
// Reset: synchronous, angle, direction and scan count cleared, scan limit set to 2.
`include "assert_macros.svh"

module sonar_sweep_polar_plotter_unit
  import ssp_pkg::*;
#(
  parameter int SWEEP_STEPS = SWEEP_STEPS_DEF,
  parameter int ROW_BYTES   = ROW_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ssp_echo_if.sink     echo,
  ssp_cfg_if.sink      cfg,
  ssp_result_if.source result
);

  logic     q_push_valid;
  logic     q_push_ready;
  ssp_job_t q_push_data;
  logic     q_pop_valid;
  logic     q_pop_ready;
  ssp_job_t q_pop_data;

  ssp_front #(
    .SWEEP_STEPS(SWEEP_STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .echo       (echo),
    .cfg        (cfg),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  ssp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_push_valid),
    .in_ready  (q_push_ready),
    .in_data   (q_push_data),
    .out_valid (q_pop_valid),
    .out_ready (q_pop_ready),
    .out_data  (q_pop_data)
  );

  ssp_back #(
    .ROW_BYTES(ROW_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .result    (result)
  );

  `SSP_ASSERT_IMP(a_done_no_plot, clk, rst, result.valid && result.sweep_done, !result.plot_valid && result.pixel_address == '0 && result.pixel_mask == '0, "sweep done item carries a plot")
  `SSP_ASSERT_IMP(a_mask_shape, clk, rst, result.valid, result.plot_valid ? $onehot(result.pixel_mask) : (result.pixel_mask == '0), "pixel mask does not match plot flag")
  `SSP_ASSERT_NEXT(a_single_pop, clk, rst, q_pop_valid && q_pop_ready, !q_pop_ready, "back end took a second item while busy")

endmodule
